/* hw/rtl/neighbor_table_anchor_control_assert.svh */
// Assertion macros for the neighbor table and anchor control block.
// Expects clk and arst_n in the scope of each use.
`ifndef NEIGHBOR_TABLE_ANCHOR_CONTROL_ASSERT_SVH
`define NEIGHBOR_TABLE_ANCHOR_CONTROL_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define NTAC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked at the next edge.
`define NTAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ntac_pkg.sv */
// Shared types and constants for the neighbor table and anchor control block.
// No dependencies.
package ntac_pkg;

	localparam int MAX_NEIGHBORS_DEF = 4;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AVOID_DIST  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_WAIT = 8'd3;

	localparam logic [15:0] AGE_LIMIT_RST   = 16'd4000;
	localparam logic [7:0]  MIN_SPACING_RST = 8'd60;
	localparam logic [7:0]  AVOID_DIST_RST  = 8'd40;
	localparam logic [15:0] ANCHOR_WAIT_RST = 16'd500;
	localparam logic [7:0]  LAST_DIST_RST   = 8'd100;

	typedef enum logic [1:0] {
		MODE_WALK     = 2'd0,
		MODE_AVOID    = 2'd1,
		MODE_HOLD     = 2'd2,
		MODE_ANCHORED = 2'd3
	} mode_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_UPDATE = 1'b1
	} state_t;

	typedef struct packed {
		logic [31:0] tick_now;
		logic        msg_valid;
		logic [15:0] sender_id;
		logic [7:0]  msg_distance;
	} in_item_t;

	typedef struct packed {
		logic [1:0] motion_mode;
		logic [2:0] neighbor_count;
		logic       anchor_pending;
		logic       is_anchored;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic wait_running;
		logic anchored;
		logic full;
	} status_t;

endpackage

/* hw/rtl/ntac_dp.sv */
// Datapath: neighbor table, configuration registers, anchor state, result register.
// Depends on ntac_pkg; driven by ntac_ctrl commands.
module ntac_dp import ntac_pkg::*; #(
	parameter int MaxNeighbors = MAX_NEIGHBORS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  in_item_t              in_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output out_item_t             out_data,
	output status_t               status
);

	localparam int CW = $clog2(MaxNeighbors + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MaxNeighbors);

	logic [15:0]   ident_q [MaxNeighbors];
	logic [31:0]   stamp_q [MaxNeighbors];
	logic [CW-1:0] count_q;
	logic [7:0]    last_dist_q;
	logic          wait_q;
	logic [31:0]   wait_start_q;
	logic          anch_q;

	logic [15:0] age_limit_q;
	logic [7:0]  min_spacing_q;
	logic [7:0]  avoid_dist_q;
	logic [15:0] anchor_wait_q;

	in_item_t  item_s1;
	out_item_t out_q;

	logic [31:0]   age;
	logic          drop;
	logic          found;
	logic [CW-1:0] hit;
	logic          kept;
	logic [CW-1:0] cnt_del;
	logic          do_app;
	logic [CW-1:0] cnt_n;
	logic [15:0]   ident_n [MaxNeighbors];
	logic [31:0]   stamp_n [MaxNeighbors];
	logic          full;
	logic [7:0]    dist_n;
	logic [31:0]   waited;
	logic          expire;
	logic          wait_n;
	logic [31:0]   wait_start_n;
	logic          anch_n;
	mode_t         mode;
	logic [CW+2:0] cnt_ext;

	// head entry age check on the incoming transaction
	always_comb begin
		age  = in_data.tick_now - stamp_q[0];
		drop = !anch_q && (count_q != '0) && (age > {16'd0, age_limit_q});
	end

	always_comb begin
		found = 1'b0;
		hit   = '0;
		for (int k = 0; k < MaxNeighbors; k++) begin
			if (!found && (CW'(k) < count_q) && (ident_q[k] == item_s1.sender_id)) begin
				found = 1'b1;
				hit   = CW'(k);
			end
		end
		kept    = item_s1.msg_distance > min_spacing_q;
		cnt_del = count_q - CW'(found);
		if (found) begin
			do_app = item_s1.msg_valid && kept;
		end else begin
			do_app = item_s1.msg_valid && !wait_q && kept && (count_q < FULL_CNT);
		end
		cnt_n = item_s1.msg_valid ? (cnt_del + CW'(do_app)) : count_q;

		for (int k = 0; k < MaxNeighbors; k++) begin
			ident_n[k] = ident_q[k];
			stamp_n[k] = stamp_q[k];
		end
		for (int k = 0; k < MaxNeighbors - 1; k++) begin
			if (item_s1.msg_valid && found && (CW'(k) >= hit)) begin
				ident_n[k] = ident_q[k+1];
				stamp_n[k] = stamp_q[k+1];
			end
		end
		for (int k = 0; k < MaxNeighbors; k++) begin
			if (do_app && (CW'(k) == cnt_del)) begin
				ident_n[k] = item_s1.sender_id;
				stamp_n[k] = item_s1.tick_now;
			end
		end

		full   = cnt_n == FULL_CNT;
		dist_n = item_s1.msg_valid ? item_s1.msg_distance : last_dist_q;
		waited = item_s1.tick_now - wait_start_q;
		expire = wait_q && (waited > {16'd0, anchor_wait_q});

		wait_n       = wait_q;
		wait_start_n = wait_start_q;
		anch_n       = 1'b0;
		if (full) begin
			mode = MODE_HOLD;
			if (!wait_q) begin
				wait_n       = 1'b1;
				wait_start_n = item_s1.tick_now;
			end
		end else if (dist_n < avoid_dist_q) begin
			mode = MODE_AVOID;
		end else begin
			mode = MODE_WALK;
		end
		if (expire) begin
			if (full) begin
				anch_n = 1'b1;
				mode   = MODE_ANCHORED;
			end else begin
				wait_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_limit_q   <= AGE_LIMIT_RST;
			min_spacing_q <= MIN_SPACING_RST;
			avoid_dist_q  <= AVOID_DIST_RST;
			anchor_wait_q <= ANCHOR_WAIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_AGE_LIMIT:   age_limit_q   <= cfg_data;
				REG_MIN_SPACING: min_spacing_q <= cfg_data[7:0];
				REG_AVOID_DIST:  avoid_dist_q  <= cfg_data[7:0];
				REG_ANCHOR_WAIT: anchor_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			last_dist_q  <= LAST_DIST_RST;
			wait_q       <= 1'b0;
			wait_start_q <= '0;
			anch_q       <= 1'b0;
		end else if (cmd.capture) begin
			if (drop) begin
				count_q <= count_q - CW'(1);
			end
		end else if (cmd.update && !anch_q) begin
			count_q      <= cnt_n;
			last_dist_q  <= dist_n;
			wait_q       <= wait_n;
			wait_start_q <= wait_start_n;
			anch_q       <= anch_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_s1 <= in_data;
			if (drop) begin
				for (int k = 0; k < MaxNeighbors - 1; k++) begin
					ident_q[k] <= ident_q[k+1];
					stamp_q[k] <= stamp_q[k+1];
				end
			end
		end else if (cmd.update && !anch_q) begin
			for (int k = 0; k < MaxNeighbors; k++) begin
				ident_q[k] <= ident_n[k];
				stamp_q[k] <= stamp_n[k];
			end
		end
	end

	assign cnt_ext = {3'd0, (anch_q ? count_q : cnt_n)};

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_q.motion_mode    <= anch_q ? MODE_ANCHORED : mode;
			out_q.neighbor_count <= cnt_ext[2:0];
			out_q.anchor_pending <= anch_q ? wait_q : wait_n;
			out_q.is_anchored    <= anch_q | anch_n;
		end
	end

	assign out_data            = out_q;
	assign status.wait_running = wait_q;
	assign status.anchored     = anch_q;
	assign status.full         = count_q == FULL_CNT;

endmodule

/* hw/rtl/ntac_ctrl.sv */
// Controller: two-state sequencer and result handshake.
// Depends on ntac_pkg; issues commands to ntac_dp.
module ntac_ctrl import ntac_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_n;
	logic   out_valid_q;
	logic   out_valid_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_n = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				// hold while the previous result is still waiting
				if (!out_valid_q || out_ready) begin
					cmd.update = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
		if (cmd.update) begin
			out_valid_n = 1'b1;
		end else if (out_ready) begin
			out_valid_n = 1'b0;
		end else begin
			out_valid_n = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/neighbor_table_anchor_control.sv */
// Top level of the neighbor table and anchor control block.
// Depends on ntac_pkg, ntac_ctrl, ntac_dp and the assertion macro header.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | in_data (in_item_t)
//  out     | output    | out_valid / out_ready | out_data (out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A transaction is accepted in ST_IDLE, where the head entry ages out;
// ST_UPDATE then runs the table search, delete-with-shift, append and anchor logic.
// The result register lets the next transaction enter while a result waits.
// A result that is not taken stalls ST_UPDATE until out_ready.
// Reset is asynchronous; the table contents are valid only below the count.
// Configuration writes are taken in any cycle.
`include "neighbor_table_anchor_control_assert.svh"

module neighbor_table_anchor_control import ntac_pkg::*; #(
	parameter int MaxNeighbors = MAX_NEIGHBORS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	ntac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ntac_dp #(
		.MaxNeighbors (MaxNeighbors)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data),
		.status    (status)
	);

	`NTAC_ASSERT_SAME(a_cmd_excl, 1'b1, !(cmd.capture && cmd.update), "capture and update overlap")
	`NTAC_ASSERT_NEXT(a_update_out, cmd.update, out_valid, "update did not present a result")
	`NTAC_ASSERT_NEXT(a_anch_sticky, status.anchored, status.anchored, "anchored flag cleared")
	`NTAC_ASSERT_SAME(a_anch_full, status.anchored, status.full && status.wait_running, "anchored without full table and wait")

endmodule

/* test/tb_neighbor_table_anchor_control.sv */
// Testbench for neighbor_table_anchor_control: a scripted opening and random control ticks,
// checked against a local model of the neighbor table and anchor wait or hand-written results.
// Depends on ntac_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_neighbor_table_anchor_control;
	import ntac_pkg::*;

	localparam int NBR_SLOTS = MAX_NEIGHBORS_DEF;
	localparam int NUM_PHASES = 7;
	localparam int NUM_WRITES = 5;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_ANCHOR_WAIT + 1'b1;

	typedef struct packed {
		logic [NBR_SLOTS-1:0][15:0] ident;
		logic [NBR_SLOTS-1:0][31:0] stamp;
		logic [2:0]                 count;
		logic [7:0]                 last_dist;
		logic                       wait_on;
		logic [31:0]                wait_t0;
		logic                       anchored;
	} nbr_table_t;

	typedef struct packed {
		logic [15:0] age_limit;
		logic [7:0]  min_spacing;
		logic [7:0]  avoid_dist;
		logic [15:0] anchor_wait;
	} ctl_regs_t;

	typedef struct packed {
		in_item_t  stim;
		logic      by_hand;
		out_item_t want;
	} script_row_t;

	localparam script_row_t SCRIPT [20] = '{
		'{'{32'd0, 1'b0, 16'h0000, 8'd0}, 1'b1, '{MODE_WALK, 3'd0, 1'b0, 1'b0}},
		'{'{32'd10, 1'b1, 16'hFFFF, 8'd255}, 1'b1, '{MODE_WALK, 3'd1, 1'b0, 1'b0}},
		'{'{32'd20, 1'b1, 16'h0000, 8'd61}, 1'b1, '{MODE_WALK, 3'd2, 1'b0, 1'b0}},
		'{'{32'd30, 1'b1, 16'h1234, 8'd60}, 1'b0, '0},
		'{'{32'd40, 1'b1, 16'h5555, 8'd0}, 1'b1, '{MODE_AVOID, 3'd2, 1'b0, 1'b0}},
		'{'{32'd50, 1'b1, 16'hFFFF, 8'd200}, 1'b0, '0},
		'{'{32'd60, 1'b1, 16'h0000, 8'd39}, 1'b0, '0},
		'{'{32'd70, 1'b0, 16'hFFFF, 8'd0}, 1'b0, '0},
		'{'{32'd80, 1'b1, 16'hAAAA, 8'd100}, 1'b0, '0},
		'{'{32'd90, 1'b1, 16'h5555, 8'd150}, 1'b0, '0},
		'{'{32'd100, 1'b1, 16'h0F0F, 8'd255}, 1'b1, '{MODE_HOLD, 3'd4, 1'b1, 1'b0}},
		'{'{32'd110, 1'b1, 16'h7777, 8'd200}, 1'b1, '{MODE_HOLD, 3'd4, 1'b1, 1'b0}},
		'{'{32'd120, 1'b1, 16'hAAAA, 8'd10}, 1'b0, '0},
		'{'{32'd130, 1'b1, 16'h7777, 8'd200}, 1'b0, '0},
		'{'{32'd601, 1'b0, 16'h0000, 8'd0}, 1'b1, '{MODE_WALK, 3'd3, 1'b0, 1'b0}},
		'{'{32'hFFFF_FF00, 1'b0, 16'h0000, 8'd0}, 1'b0, '0},
		'{'{32'hFFFF_FF10, 1'b1, 16'h3333, 8'd90}, 1'b0, '0},
		'{'{32'hFFFF_FF20, 1'b0, 16'h0000, 8'd0}, 1'b0, '0},
		'{'{32'h0000_0E00, 1'b0, 16'h0000, 8'd0}, 1'b0, '0},
		'{'{32'h0000_0F00, 1'b0, 16'h0000, 8'd0}, 1'b0, '0}
	};

	localparam ctl_regs_t PHASE_REGS [NUM_PHASES] = '{
		'{AGE_LIMIT_RST, MIN_SPACING_RST, AVOID_DIST_RST, ANCHOR_WAIT_RST},
		'{16'd200, 8'd60, 8'd40, 16'd300},
		'{16'd0, 8'd0, 8'd0, 16'd65535},
		'{16'd65535, 8'd255, 8'd255, 16'd1000},
		'{16'd1500, 8'd128, 8'd128, 16'd200},
		'{16'd800, 8'd30, 8'd90, 16'd400},
		'{16'd3000, 8'd50, 8'd60, 16'd0}
	};

	localparam int PHASE_ITEMS [NUM_PHASES] = '{60, 75, 75, 30, 75, 75, 45};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	nbr_table_t  nbr_tbl;
	ctl_regs_t   regs;
	out_item_t   pending_status_q [$];
	logic [15:0] id_pool [6];
	logic [31:0] tick_cursor;
	bit          calm = 1'b0;
	int unsigned mismatch_cnt = 0;

	neighbor_table_anchor_control i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void remove_slot(input int pos);
		for (int k = pos; k < NBR_SLOTS - 1; k++) begin
			nbr_tbl.ident[k] = nbr_tbl.ident[k + 1];
			nbr_tbl.stamp[k] = nbr_tbl.stamp[k + 1];
		end
		nbr_tbl.count = nbr_tbl.count - 3'd1;
	endfunction

	function automatic void push_slot(input logic [15:0] id, input logic [31:0] stamp);
		if (int'(nbr_tbl.count) < NBR_SLOTS) begin
			nbr_tbl.ident[nbr_tbl.count] = id;
			nbr_tbl.stamp[nbr_tbl.count] = stamp;
			nbr_tbl.count = nbr_tbl.count + 3'd1;
		end
	endfunction

	function automatic out_item_t step_table(input in_item_t it);
		out_item_t   r;
		mode_t       mode;
		int          hit;
		logic        full;
		logic [31:0] age;
		logic [31:0] elapsed;

		hit = -1;
		if (nbr_tbl.anchored) begin
			r = '{MODE_ANCHORED, nbr_tbl.count, nbr_tbl.wait_on, 1'b1};
			return r;
		end
		age = it.tick_now - nbr_tbl.stamp[0];
		if (nbr_tbl.count != 0 && age > {16'd0, regs.age_limit})
			remove_slot(0);
		if (it.msg_valid) begin
			nbr_tbl.last_dist = it.msg_distance;
			for (int k = 0; k < NBR_SLOTS; k++)
				if (hit < 0 && k < int'(nbr_tbl.count) && nbr_tbl.ident[k] == it.sender_id)
					hit = k;
			if (hit >= 0) begin
				remove_slot(hit);
				if (it.msg_distance > regs.min_spacing)
					push_slot(it.sender_id, it.tick_now);
			end else if (!nbr_tbl.wait_on && it.msg_distance > regs.min_spacing) begin
				push_slot(it.sender_id, it.tick_now);
			end
		end
		full = (int'(nbr_tbl.count) == NBR_SLOTS);
		if (full) begin
			mode = MODE_HOLD;
			if (!nbr_tbl.wait_on) begin
				nbr_tbl.wait_on = 1'b1;
				nbr_tbl.wait_t0 = it.tick_now;
			end
		end else begin
			mode = (nbr_tbl.last_dist < regs.avoid_dist) ? MODE_AVOID : MODE_WALK;
		end
		elapsed = it.tick_now - nbr_tbl.wait_t0;
		if (nbr_tbl.wait_on && elapsed > {16'd0, regs.anchor_wait}) begin
			if (full) begin
				nbr_tbl.anchored = 1'b1;
				mode = MODE_ANCHORED;
			end else begin
				nbr_tbl.wait_on = 1'b0;
			end
		end
		r.motion_mode = mode;
		r.neighbor_count = nbr_tbl.count;
		r.anchor_pending = nbr_tbl.wait_on;
		r.is_anchored = nbr_tbl.anchored;
		return r;
	endfunction

	task automatic send_tick(input in_item_t it, input out_item_t want);
		int gap;

		pending_status_q.push_back(want);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_status();
		in_valid <= 1'b0;
		while (pending_status_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stall_gen
		int n;

		wait (arst_n);
		forever begin
			n = $urandom_range(1, 16);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat (n) @(posedge clk);
		end
	end

	always @(posedge clk) begin : status_check
		out_item_t want;

		if (arst_n && out_valid && out_ready) begin
			if (pending_status_q.size() == 0) begin
				$error("status transaction with none pending: mode %0d count %0d",
					out_data.motion_mode, out_data.neighbor_count);
				mismatch_cnt++;
			end else begin
				want = pending_status_q.pop_front();
				if (out_data.motion_mode !== want.motion_mode) begin
					$error("motion_mode: expected %0d, got %0d",
						want.motion_mode, out_data.motion_mode);
					mismatch_cnt++;
				end
				if (out_data.neighbor_count !== want.neighbor_count) begin
					$error("neighbor_count: expected %0d, got %0d",
						want.neighbor_count, out_data.neighbor_count);
					mismatch_cnt++;
				end
				if (out_data.anchor_pending !== want.anchor_pending) begin
					$error("anchor_pending: expected %0d, got %0d",
						want.anchor_pending, out_data.anchor_pending);
					mismatch_cnt++;
				end
				if (out_data.is_anchored !== want.is_anchored) begin
					$error("is_anchored: expected %0d, got %0d",
						want.is_anchored, out_data.is_anchored);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin : stimulus
		in_item_t              item;
		out_item_t             want;
		nbr_table_t            saved;
		ctl_regs_t             next_regs;
		logic [CFG_IDX_W-1:0]  wr_idx [NUM_WRITES];
		logic [CFG_DATA_W-1:0] wr_val [NUM_WRITES];
		int unsigned           step_max;
		int unsigned           roll;

		nbr_tbl = '0;
		nbr_tbl.last_dist = LAST_DIST_RST;
		regs = PHASE_REGS[0];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[r]) begin
			want = step_table(SCRIPT[r].stim);
			send_tick(SCRIPT[r].stim, SCRIPT[r].by_hand ? SCRIPT[r].want : want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				drain_status();
				calm = (p == NUM_PHASES - 1);
				next_regs = PHASE_REGS[p];
				wr_idx[0] = 8'($urandom_range(REG_FIRST_UNUSED, {CFG_IDX_W{1'b1}}));
				wr_val[0] = 16'($urandom());
				wr_idx[1] = REG_AGE_LIMIT;
				wr_val[1] = next_regs.age_limit;
				wr_idx[2] = REG_MIN_SPACING;
				wr_val[2] = {8'($urandom()), next_regs.min_spacing};
				wr_idx[3] = REG_AVOID_DIST;
				wr_val[3] = {8'($urandom()), next_regs.avoid_dist};
				wr_idx[4] = REG_ANCHOR_WAIT;
				wr_val[4] = next_regs.anchor_wait;
				for (int w = 0; w < NUM_WRITES; w++) begin
					cfg_valid <= 1'b1;
					cfg_index <= wr_idx[w];
					cfg_data <= wr_val[w];
					do @(posedge clk); while (!cfg_ready);
					case (wr_idx[w])
						REG_AGE_LIMIT:   regs.age_limit = wr_val[w];
						REG_MIN_SPACING: regs.min_spacing = wr_val[w][7:0];
						REG_AVOID_DIST:  regs.avoid_dist = wr_val[w][7:0];
						REG_ANCHOR_WAIT: regs.anchor_wait = wr_val[w];
						default: ;
					endcase
				end
				cfg_valid <= 1'b0;
			end

			foreach (id_pool[i])
				id_pool[i] = 16'($urandom());
			tick_cursor = ~32'($urandom_range(0, 30000));
			step_max = 32'(regs.age_limit >> 3) + 1;

			for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					tick_cursor = $urandom();
				else if (roll < 10)
					tick_cursor += 32'($urandom_range(0, 70000));
				else
					tick_cursor += 32'($urandom_range(0, step_max));
				item.tick_now = tick_cursor;
				item.msg_valid = ($urandom_range(0, 9) < 7);
				item.sender_id = ($urandom_range(0, 9) == 0) ? 16'($urandom())
					: id_pool[$urandom_range(0, 5)];
				case ($urandom_range(0, 7))
					0: item.msg_distance = regs.min_spacing;
					1: item.msg_distance = regs.min_spacing + 8'd1;
					2: item.msg_distance = regs.avoid_dist - 8'd1;
					default: item.msg_distance = 8'($urandom_range(0, 255));
				endcase
				saved = nbr_tbl;
				want = step_table(item);
				// hold off anchoring until the last phase: replay at the wait start tick
				if (p != NUM_PHASES - 1 && want.is_anchored) begin
					nbr_tbl = saved;
					item.tick_now = saved.wait_t0;
					want = step_table(item);
				end
				send_tick(item, want);
			end
		end

		drain_status();
		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#1000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
